// ===== design/ied_pkg.sv =====
`timescale 1ns / 1ps
// Package for the infix digit expression evaluator: widths, codes, word types.
// No dependencies.
package ied_pkg;

  localparam int VALUE_WIDTH = 32;               // arithmetic width, wraps
  localparam int CNT_W       = $clog2(VALUE_WIDTH);

  typedef logic [VALUE_WIDTH-1:0] val_t;

  // ASCII codes
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_DIVZ    = 2'd1;
  localparam logic [1:0] STAT_MISSING = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_MUL  = 2'd1,
    OP_DIV  = 2'd2
  } prod_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_NEGQ,
    S_FOLD
  } ied_state_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       final_char;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } out_word_t;

  // core -> top result offer
  typedef struct packed {
    logic      valid;
    out_word_t word;
  } ied_emit_t;

  // shared adder/subtractor result
  typedef struct packed {
    val_t res;
    logic cout;
  } ied_alu_t;

  // operand value of a character; non-digits count as 0
  function automatic logic [3:0] digit_val(input logic [7:0] c);
    logic [3:0] d;
    d = 4'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = 4'(c - CH_ZERO);
    end
    return d;
  endfunction

endpackage

// ===== design/ied_alu.sv =====
`timescale 1ns / 1ps
// Shared VALUE_WIDTH adder/subtractor with carry out (carry = no borrow on sub).
// Depends on ied_pkg.
module ied_alu
  import ied_pkg::*;
(
  input  val_t     a,
  input  val_t     b,
  input  logic     sub,
  output ied_alu_t y
);

  logic [VALUE_WIDTH:0] sum;

  assign sum    = {1'b0, a} + {1'b0, b ^ {VALUE_WIDTH{sub}}} + (VALUE_WIDTH+1)'(sub);
  assign y.res  = sum[VALUE_WIDTH-1:0];
  assign y.cout = sum[VALUE_WIDTH];

endmodule

// ===== design/ied_core.sv =====
`timescale 1ns / 1ps
// Sequencer and evaluation state; every add, subtract, negate, multiply step
// and divide step goes through one ied_alu. Depends on ied_pkg, ied_alu.
module ied_core
  import ied_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_word_t  in_word,
  input  logic      emit_ack,
  output logic      idle,
  output ied_emit_t emit
);

  ied_state_t state_r, state_nxt;
  logic [7:0] ch_r, ch_nxt;
  logic       last_r, last_nxt;
  val_t       sum_r, sum_nxt;
  val_t       term_r, term_nxt;
  logic       sub_r, sub_nxt;
  prod_op_t   op_r, op_nxt;
  logic       want_r, want_nxt;
  logic       halt_r, halt_nxt;
  logic       zdiv_r, zdiv_nxt;
  val_t       work_r, work_nxt;      // mul accumulator / div dividend+quotient
  logic [3:0] rem_r, rem_nxt;
  logic       neg_r, neg_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  val_t       alu_a, alu_b;
  logic       alu_sub;
  ied_alu_t   alu_y;
  logic [3:0] digit;
  logic [4:0] trial;
  val_t       quo;
  ied_state_t fin_state;

  ied_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .y   (alu_y)
  );

  assign digit     = digit_val(ch_r);
  assign trial     = {rem_r, work_r[VALUE_WIDTH-1]};
  assign quo       = {work_r[VALUE_WIDTH-2:0], alu_y.cout};
  assign fin_state = last_r ? S_FOLD : S_IDLE;
  assign idle      = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sum_r   <= '0;
      term_r  <= '0;
      sub_r   <= 1'b0;
      op_r    <= OP_NONE;
      want_r  <= 1'b1;
      halt_r  <= 1'b0;
      zdiv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      term_r  <= term_nxt;
      sub_r   <= sub_nxt;
      op_r    <= op_nxt;
      want_r  <= want_nxt;
      halt_r  <= halt_nxt;
      zdiv_r  <= zdiv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r   <= ch_nxt;
    last_r <= last_nxt;
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    neg_r  <= neg_nxt;
    cnt_r  <= cnt_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    last_nxt  = last_r;
    sum_nxt   = sum_r;
    term_nxt  = term_r;
    sub_nxt   = sub_r;
    op_nxt    = op_r;
    want_nxt  = want_r;
    halt_nxt  = halt_r;
    zdiv_nxt  = zdiv_r;
    work_nxt  = work_r;
    rem_nxt   = rem_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    alu_a     = '0;
    alu_b     = '0;
    alu_sub   = 1'b0;
    emit      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ch_nxt    = in_word.ch;
          last_nxt  = in_word.final_char;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = fin_state;
        if (!halt_r && ch_r != CH_SPACE) begin
          if (want_r) begin
            case (op_r)
              OP_MUL: begin
                work_nxt  = '0;
                cnt_nxt   = CNT_W'(3);
                state_nxt = S_MUL;
              end
              OP_DIV: begin
                if (digit == 4'd0) begin
                  zdiv_nxt = 1'b1;
                  term_nxt = '0;
                  op_nxt   = OP_NONE;
                  want_nxt = 1'b0;
                end else begin
                  // magnitude of the dividend
                  alu_b     = term_r;
                  alu_sub   = 1'b1;
                  neg_nxt   = term_r[VALUE_WIDTH-1];
                  work_nxt  = term_r[VALUE_WIDTH-1] ? alu_y.res : term_r;
                  rem_nxt   = 4'd0;
                  cnt_nxt   = CNT_W'(VALUE_WIDTH-1);
                  state_nxt = S_DIV;
                end
              end
              default: begin
                term_nxt = VALUE_WIDTH'(digit);
                op_nxt   = OP_NONE;
                want_nxt = 1'b0;
              end
            endcase
          end else begin
            case (ch_r) inside
              CH_STAR: begin
                op_nxt   = OP_MUL;
                want_nxt = 1'b1;
              end
              CH_SLASH: begin
                op_nxt   = OP_DIV;
                want_nxt = 1'b1;
              end
              CH_PLUS, CH_MINUS: begin
                alu_a    = sum_r;
                alu_b    = term_r;
                alu_sub  = sub_r;
                sum_nxt  = alu_y.res;
                term_nxt = '0;
                sub_nxt  = (ch_r == CH_MINUS);
                op_nxt   = OP_NONE;
                want_nxt = 1'b1;
              end
              default: halt_nxt = 1'b1;
            endcase
          end
        end
      end

      S_MUL: begin
        // shift-add over the 4 digit bits, MSB first
        alu_a    = {work_r[VALUE_WIDTH-2:0], 1'b0};
        alu_b    = digit[cnt_r[1:0]] ? term_r : '0;
        work_nxt = alu_y.res;
        cnt_nxt  = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          term_nxt  = alu_y.res;
          op_nxt    = OP_NONE;
          want_nxt  = 1'b0;
          state_nxt = fin_state;
        end
      end

      S_DIV: begin
        // restoring step: one quotient bit per cycle
        alu_a    = VALUE_WIDTH'(trial);
        alu_b    = VALUE_WIDTH'(digit);
        alu_sub  = 1'b1;
        rem_nxt  = alu_y.cout ? alu_y.res[3:0] : trial[3:0];
        work_nxt = quo;
        cnt_nxt  = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          if (neg_r) begin
            state_nxt = S_NEGQ;
          end else begin
            term_nxt  = quo;
            op_nxt    = OP_NONE;
            want_nxt  = 1'b0;
            state_nxt = fin_state;
          end
        end
      end

      S_NEGQ: begin
        alu_b     = work_r;
        alu_sub   = 1'b1;
        term_nxt  = alu_y.res;
        op_nxt    = OP_NONE;
        want_nxt  = 1'b0;
        state_nxt = fin_state;
      end

      S_FOLD: begin
        alu_a            = sum_r;
        alu_b            = term_r;
        alu_sub          = sub_r;
        emit.valid       = 1'b1;
        emit.word.value  = 32'(signed'(alu_y.res));
        emit.word.status = zdiv_r ? STAT_DIVZ :
                           (want_r && !halt_r) ? STAT_MISSING : STAT_OK;
        if (emit_ack) begin
          sum_nxt   = '0;
          term_nxt  = '0;
          sub_nxt   = 1'b0;
          op_nxt    = OP_NONE;
          want_nxt  = 1'b1;
          halt_nxt  = 1'b0;
          zdiv_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== design/infix_digit_expression_evaluator.sv =====
`timescale 1ns / 1ps
// Top level of the infix digit expression evaluator: handshakes, result register.
// Depends on ied_pkg, ied_core (which uses ied_alu).
//
//   channel | dir | ports                        | word
//   --------+-----+------------------------------+---------------------------
//   input   | in  | in_valid  in_ready  in_data  | in_word_t  {ch, final_char}
//   result  | out | out_valid out_ready out_data | out_word_t {value, status}
//
// Per word: a space, operator, plain operand or skipped char passes through
// S_EXEC only; an operand after '*' adds 4 shift-add steps; a nonzero
// operand after '/' adds one restoring step per bit of the 32-bit dividend, plus
// the quotient negation for a negative dividend; a zero divisor after '/' adds none.
// A final word adds the S_FOLD state. The single shared adder sets all of this.
// Reset (rst_n low, synchronous) clears the expression state and the valid flag
// of the result register. A waiting result does not block new words; only the next final
// word waits in its fold cycle until the result register frees up.
module infix_digit_expression_evaluator
  import ied_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  logic      core_idle;
  logic      emit_ack;
  ied_emit_t emit;
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_data_r, out_data_nxt;

  // result register can take a word when empty or being drained
  assign emit_ack = !out_valid_r || out_ready;
  assign in_ready = core_idle;

  ied_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_valid && in_ready),
    .in_word  (in_data),
    .emit_ack (emit_ack),
    .idle     (core_idle),
    .emit     (emit)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit.valid && emit_ack) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit.word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // one word at a time: the core is busy right after taking a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while core busy");

  // a result is never offered in the cycle right after a word is taken
  a_no_early_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !emit.valid)
    else $error("result offered without evaluation");

  // a granted result lands in the result register
  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (emit.valid && emit_ack) |=> (out_valid && out_data.status != 2'd3))
    else $error("granted result lost");

endmodule
